### rtl/rofaf_pkg.sv
`default_nettype none

package rofaf_pkg;

    localparam int DIV_W = 32;

    localparam logic [DIV_W-1:0] RAND_LIMIT = 32'h7FFF_FFFF;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_EDGE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SHUFFLE = 2'd1,
        CMD_EMIT    = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_D,
        S_WAIT_D,
        S_DIV_Q,
        S_WAIT_Q,
        S_SW_RD,
        S_SW_WR1,
        S_SW_WR2,
        S_E_RD,
        S_E_POS,
        S_E_CMP,
        S_E_END
    } t_state;

endpackage

`default_nettype wire

### rtl/random_order_feedback_arc_filter_core.sv
`default_nettype none

// Channel  Handshake                 Payload
// input    i_in_valid / o_in_stall   i_command, i_edge_slot, i_source_node,
//                                    i_target_node, i_random_word
// output   o_out_valid / i_out_stall o_out_source, o_out_target, o_edge_present, o_last
// config   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A load request is written as it is accepted. A shuffle request runs two passes of
// the shared one-bit-per-cycle 32-bit divider plus the swap through the order and
// position memories. An emit request reads, looks up and compares each walked edge,
// then sends a result flagged last, held while the output stalls. Reset is synchronous;
// the order and position tables return to identity at once through per-entry valid bits.

module random_order_feedback_arc_filter_core #(
    parameter int MAX_EDGES = 64,
    parameter int MAX_NODES = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [5:0]  i_edge_slot,
    input  wire logic [6:0]  i_source_node,
    input  wire logic [6:0]  i_target_node,
    input  wire logic [30:0] i_random_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [6:0]  o_out_source,
    output logic      [6:0]  o_out_target,
    output logic             o_edge_present,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int DW  = rofaf_pkg::DIV_W;
    localparam int PW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int NXW = (NCW > 8) ? NCW : 8;
    localparam int OW  = (NCW > 7) ? NCW : 7;
    localparam int CW  = (PW > 7) ? PW : 7;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW  = $clog2(MAX_EDGES + 1);
    localparam int KXW = (KW > 7) ? KW : 7;
    localparam int SLW = (KW > 6) ? KW : 6;

    rofaf_pkg::t_state r_state, n_state;

    logic [7:0]     r_node_count;
    logic [6:0]     r_edge_count;
    logic [PW-1:0]  r_step;
    logic [PW-1:0]  r_i;
    logic [PW-1:0]  r_j;
    logic [NCW-1:0] r_n;
    logic [30:0]    r_rand;
    logic [DW-1:0]  r_d;
    logic [KW-1:0]  r_k;
    logic [KW-1:0]  r_walk;
    logic           r_pend_valid;
    logic [6:0]     r_pend_src, r_pend_tgt;
    logic [6:0]     r_e_src, r_e_tgt;
    logic           r_out_valid;
    logic [6:0]     r_out_src, r_out_tgt;
    logic           r_out_present, r_out_last;

    logic [6:0]     r_src_mem [MAX_EDGES];
    logic [6:0]     r_tgt_mem [MAX_EDGES];

    logic [NXW-1:0] nc_ext;
    logic [NCW-1:0] n_eff;
    logic [PW-1:0]  i_first;
    logic [KXW-1:0] ec_ext;
    logic [KW-1:0]  walk;
    logic [NCW-1:0] n_minus_i;
    logic [NCW-1:0] i_inc;
    logic [PW-1:0]  n_step;
    logic [PW-1:0]  j_calc;

    logic           in_acc;
    logic           edge_wr;
    logic           edge_rd;
    logic           div_start;
    logic [DW-1:0]  div_dvd;
    logic [DW-1:0]  div_dvs;
    logic           div_done;
    logic [DW-1:0]  div_quot;

    logic           perm_rd_en, perm_wr_en;
    logic [PW-1:0]  ord_wa, ord_wd, pos_wa, pos_wd;
    logic [PW-1:0]  ord_a, ord_b, pos_a, pos_b;

    logic [CW-1:0]  ps, pt;
    logic           hit;
    logic           out_free;
    logic           cmp_push;
    logic           cmp_wait;
    logic           out_load;
    logic [6:0]     ld_src, ld_tgt;
    logic           ld_present, ld_last;

    always_comb begin
        nc_ext = NXW'(r_node_count);
        if (nc_ext == '0) begin
            n_eff = NCW'(1);
        end else if (nc_ext > NXW'(MAX_NODES)) begin
            n_eff = NCW'(MAX_NODES);
        end else begin
            n_eff = NCW'(nc_ext);
        end
        i_first = (NCW'(r_step) >= n_eff) ? '0 : r_step;

        ec_ext = KXW'(r_edge_count);
        walk   = (ec_ext > KXW'(MAX_EDGES)) ? KW'(MAX_EDGES) : KW'(ec_ext);

        n_minus_i = r_n - NCW'(r_i);
        i_inc     = NCW'(r_i) + NCW'(1);
        n_step    = (i_inc >= r_n) ? '0 : PW'(i_inc);
        if (div_quot >= DW'(n_minus_i)) begin
            j_calc = PW'(r_n - NCW'(1));
        end else begin
            j_calc = PW'(NCW'(r_i) + div_quot[NCW-1:0]);
        end

        ps  = (OW'(r_e_src) >= OW'(MAX_NODES)) ? CW'(r_e_src) : CW'(pos_a);
        pt  = (OW'(r_e_tgt) >= OW'(MAX_NODES)) ? CW'(r_e_tgt) : CW'(pos_b);
        hit = ps > pt;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rofaf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (rofaf_pkg::t_cmd'(i_command))
                        rofaf_pkg::CMD_SHUFFLE: n_state = rofaf_pkg::S_DIV_D;
                        rofaf_pkg::CMD_EMIT:    n_state = rofaf_pkg::S_E_RD;
                        default:                n_state = rofaf_pkg::S_IDLE;
                    endcase
                end
            end
            rofaf_pkg::S_DIV_D:  n_state = rofaf_pkg::S_WAIT_D;
            rofaf_pkg::S_WAIT_D: begin
                if (div_done) begin
                    n_state = rofaf_pkg::S_DIV_Q;
                end
            end
            rofaf_pkg::S_DIV_Q:  n_state = rofaf_pkg::S_WAIT_Q;
            rofaf_pkg::S_WAIT_Q: begin
                if (div_done) begin
                    n_state = rofaf_pkg::S_SW_RD;
                end
            end
            rofaf_pkg::S_SW_RD:  n_state = rofaf_pkg::S_SW_WR1;
            rofaf_pkg::S_SW_WR1: n_state = rofaf_pkg::S_SW_WR2;
            rofaf_pkg::S_SW_WR2: n_state = rofaf_pkg::S_IDLE;
            rofaf_pkg::S_E_RD: begin
                n_state = (r_k == r_walk) ? rofaf_pkg::S_E_END : rofaf_pkg::S_E_POS;
            end
            rofaf_pkg::S_E_POS:  n_state = rofaf_pkg::S_E_CMP;
            rofaf_pkg::S_E_CMP: begin
                if (!cmp_wait) begin
                    n_state = rofaf_pkg::S_E_RD;
                end
            end
            rofaf_pkg::S_E_END: begin
                if (out_free) begin
                    n_state = rofaf_pkg::S_IDLE;
                end
            end
            default: n_state = rofaf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_acc     = 1'b0;
        edge_wr    = 1'b0;
        edge_rd    = 1'b0;
        div_start  = 1'b0;
        div_dvd    = rofaf_pkg::RAND_LIMIT;
        div_dvs    = DW'(n_minus_i);
        perm_rd_en = 1'b0;
        perm_wr_en = 1'b0;
        ord_wa     = r_i;
        ord_wd     = ord_b;
        pos_wa     = ord_b;
        pos_wd     = r_i;
        out_free   = !r_out_valid || !i_out_stall;
        cmp_push   = 1'b0;
        cmp_wait   = 1'b0;
        out_load   = 1'b0;
        ld_src     = r_pend_src;
        ld_tgt     = r_pend_tgt;
        ld_present = 1'b1;
        ld_last    = 1'b0;
        unique case (r_state)
            rofaf_pkg::S_IDLE: begin
                in_acc  = i_in_valid;
                edge_wr = i_in_valid && (i_command == rofaf_pkg::CMD_LOAD)
                          && (SLW'(i_edge_slot) < SLW'(MAX_EDGES));
            end
            rofaf_pkg::S_DIV_D: begin
                div_start = 1'b1;
            end
            rofaf_pkg::S_DIV_Q: begin
                div_start = 1'b1;
                div_dvd   = DW'(r_rand);
                div_dvs   = r_d;
            end
            rofaf_pkg::S_SW_RD: begin
                perm_rd_en = 1'b1;
            end
            rofaf_pkg::S_SW_WR1: begin
                perm_wr_en = 1'b1;
            end
            rofaf_pkg::S_SW_WR2: begin
                perm_wr_en = 1'b1;
                ord_wa     = r_j;
                ord_wd     = ord_a;
                pos_wa     = ord_a;
                pos_wd     = r_j;
            end
            rofaf_pkg::S_E_RD: begin
                edge_rd = (r_k != r_walk);
            end
            rofaf_pkg::S_E_POS: begin
                perm_rd_en = 1'b1;
            end
            rofaf_pkg::S_E_CMP: begin
                cmp_push = hit && r_pend_valid;
                cmp_wait = cmp_push && !out_free;
                out_load = cmp_push && out_free;
            end
            rofaf_pkg::S_E_END: begin
                out_load = out_free;
                ld_last  = 1'b1;
                if (!r_pend_valid) begin
                    ld_src     = '0;
                    ld_tgt     = '0;
                    ld_present = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rofaf_pkg::S_IDLE;
            r_node_count <= 8'd1;
            r_edge_count <= 7'd1;
            r_step       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    rofaf_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    rofaf_pkg::CFG_EDGE_COUNT: r_edge_count <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc && (i_command == rofaf_pkg::CMD_EMIT)) begin
                r_pend_valid <= 1'b0;
            end
            if (r_state == rofaf_pkg::S_SW_WR2) begin
                r_step <= n_step;
            end
            if ((r_state == rofaf_pkg::S_E_CMP) && hit && !cmp_wait) begin
                r_pend_valid <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_n    <= n_eff;
            r_i    <= i_first;
            r_rand <= i_random_word;
            r_walk <= walk;
            r_k    <= '0;
        end
        if ((r_state == rofaf_pkg::S_WAIT_D) && div_done) begin
            r_d <= div_quot + DW'(1);
        end
        if ((r_state == rofaf_pkg::S_WAIT_Q) && div_done) begin
            r_j <= j_calc;
        end
        if ((r_state == rofaf_pkg::S_E_CMP) && !cmp_wait) begin
            r_k <= r_k + KW'(1);
            if (hit) begin
                r_pend_src <= r_e_src;
                r_pend_tgt <= r_e_tgt;
            end
        end
        if (out_load) begin
            r_out_src     <= ld_src;
            r_out_tgt     <= ld_tgt;
            r_out_present <= ld_present;
            r_out_last    <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (edge_wr) begin
            r_src_mem[EAW'(i_edge_slot)] <= i_source_node;
            r_tgt_mem[EAW'(i_edge_slot)] <= i_target_node;
        end
        if (edge_rd) begin
            r_e_src <= r_src_mem[r_k[EAW-1:0]];
            r_e_tgt <= r_tgt_mem[r_k[EAW-1:0]];
        end
    end

    rofaf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    rofaf_perm #(
        .MAX_NODES (MAX_NODES)
    ) u_perm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (perm_rd_en),
        .i_ord_ra (r_i),
        .i_ord_rb (r_j),
        .i_pos_ra (PW'(r_e_src)),
        .i_pos_rb (PW'(r_e_tgt)),
        .o_ord_a  (ord_a),
        .o_ord_b  (ord_b),
        .o_pos_a  (pos_a),
        .o_pos_b  (pos_b),
        .i_wr_en  (perm_wr_en),
        .i_ord_wa (ord_wa),
        .i_ord_wd (ord_wd),
        .i_pos_wa (pos_wa),
        .i_pos_wd (pos_wd)
    );

    assign o_in_stall     = (r_state != rofaf_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_out_source   = r_out_src;
    assign o_out_target   = r_out_tgt;
    assign o_edge_present = r_out_present;
    assign o_last         = r_out_last;

`ifndef SYNTH
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == rofaf_pkg::S_WAIT_D) || (r_state == rofaf_pkg::S_WAIT_Q)))
        else $error("divider finished outside a wait state");

    a_swap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rofaf_pkg::S_SW_RD) |-> ((NCW'(r_j) < r_n) && (r_i <= r_j)))
        else $error("swap partner outside the shuffled range");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rofaf_pkg::S_E_POS) |-> (r_k < r_walk))
        else $error("edge walk past its end");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_present) |-> r_out_last)
        else $error("empty marker not flagged last");
`endif

endmodule

`default_nettype wire

### rtl/rofaf_div.sv
`default_nettype none

module rofaf_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rofaf_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [rofaf_pkg::DIV_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic [rofaf_pkg::DIV_W-1:0]       o_quot
);

    localparam int DW = rofaf_pkg::DIV_W;
    localparam int CNW = $clog2(DW);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_quo;
    logic [DW-1:0]  r_dvs;

    logic [DW:0]    shifted;
    logic [DW:0]    diff;
    logic           q_bit;
    logic [DW-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_dvs};
        q_bit   = ~diff[DW];
        n_rem   = q_bit ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

### rtl/rofaf_perm.sv
`default_nettype none

module rofaf_perm #(
    parameter  int MAX_NODES = 128,
    localparam int PW        = $clog2(MAX_NODES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [PW-1:0] i_ord_ra,
    input  wire logic [PW-1:0] i_ord_rb,
    input  wire logic [PW-1:0] i_pos_ra,
    input  wire logic [PW-1:0] i_pos_rb,
    output logic      [PW-1:0] o_ord_a,
    output logic      [PW-1:0] o_ord_b,
    output logic      [PW-1:0] o_pos_a,
    output logic      [PW-1:0] o_pos_b,
    input  wire logic          i_wr_en,
    input  wire logic [PW-1:0] i_ord_wa,
    input  wire logic [PW-1:0] i_ord_wd,
    input  wire logic [PW-1:0] i_pos_wa,
    input  wire logic [PW-1:0] i_pos_wd
);

    // An entry that was never written reads as its own index.
    logic [PW-1:0]        r_ord_mem [MAX_NODES];
    logic [PW-1:0]        r_pos_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_ord_vld;
    logic [MAX_NODES-1:0] r_pos_vld;

    logic [PW-1:0] r_ord_da, r_ord_db, r_pos_da, r_pos_db;
    logic [PW-1:0] r_ord_aa, r_ord_ab, r_pos_aa, r_pos_ab;
    logic          r_ord_va, r_ord_vb, r_pos_va, r_pos_vb;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ord_mem[i_ord_wa] <= i_ord_wd;
            r_pos_mem[i_pos_wa] <= i_pos_wd;
        end
        if (i_rd_en) begin
            r_ord_da <= r_ord_mem[i_ord_ra];
            r_ord_db <= r_ord_mem[i_ord_rb];
            r_pos_da <= r_pos_mem[i_pos_ra];
            r_pos_db <= r_pos_mem[i_pos_rb];
            r_ord_aa <= i_ord_ra;
            r_ord_ab <= i_ord_rb;
            r_pos_aa <= i_pos_ra;
            r_pos_ab <= i_pos_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ord_vld <= '0;
            r_pos_vld <= '0;
            r_ord_va  <= 1'b0;
            r_ord_vb  <= 1'b0;
            r_pos_va  <= 1'b0;
            r_pos_vb  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ord_vld[i_ord_wa] <= 1'b1;
                r_pos_vld[i_pos_wa] <= 1'b1;
            end
            if (i_rd_en) begin
                r_ord_va <= r_ord_vld[i_ord_ra];
                r_ord_vb <= r_ord_vld[i_ord_rb];
                r_pos_va <= r_pos_vld[i_pos_ra];
                r_pos_vb <= r_pos_vld[i_pos_rb];
            end
        end
    end

    assign o_ord_a = r_ord_va ? r_ord_da : r_ord_aa;
    assign o_ord_b = r_ord_vb ? r_ord_db : r_ord_ab;
    assign o_pos_a = r_pos_va ? r_pos_da : r_pos_aa;
    assign o_pos_b = r_pos_vb ? r_pos_db : r_pos_ab;

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;

    localparam logic [1:0]  CMD_NONE      = 2'd3;
    localparam int          EDGE_SLOTS    = 64;
    localparam int          NODE_SLOTS    = 128;
    localparam int          SETTLE_CYCLES = 200;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          IDLE_PERCENT  = 31;
    localparam int          LIMIT_CYCLES  = 1000000;
    localparam logic [30:0] WORD_MAX      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [6:0] src;
        logic [6:0] tgt;
        logic       present;
        logic       last;
    } t_arc_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [1:0]  i_command      = '0;
    logic [5:0]  i_edge_slot    = '0;
    logic [6:0]  i_source_node  = '0;
    logic [6:0]  i_target_node  = '0;
    logic [30:0] i_random_word  = '0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic        i_cfg_index    = 1'b0;
    logic [7:0]  i_cfg_data     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [6:0]  o_out_source;
    logic [6:0]  o_out_target;
    logic        o_edge_present;
    logic        o_last;
    logic        o_cfg_ready;

    logic [6:0]  arc_src [EDGE_SLOTS];
    logic [6:0]  arc_tgt [EDGE_SLOTS];
    logic [6:0]  rank_node [NODE_SLOTS];
    logic [6:0]  node_rank [NODE_SLOTS];
    int unsigned swap_index;
    logic [7:0]  node_cnt_reg;
    logic [6:0]  edge_cnt_reg;
    t_arc_result expected_arcs [$];

    int   mismatches  = 0;
    int   cycle_count = 0;
    int   hold_left   = 0;
    logic holdoff_req = 1'b0;
    bit   tx_idle_on  = 1'b1;
    bit   rx_idle_on  = 1'b1;

    random_order_feedback_arc_filter_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_edge_slot    (i_edge_slot),
        .i_source_node  (i_source_node),
        .i_target_node  (i_target_node),
        .i_random_word  (i_random_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_source   (o_out_source),
        .o_out_target   (o_out_target),
        .o_edge_present (o_edge_present),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned active_nodes();
        if (node_cnt_reg == 0) begin
            return 1;
        end
        if (node_cnt_reg > NODE_SLOTS) begin
            return NODE_SLOTS;
        end
        return 32'(node_cnt_reg);
    endfunction

    function automatic void predict_shuffle(input logic [30:0] word);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned w;
        logic [6:0]  a;
        logic [6:0]  b;
        n = active_nodes();
        i = swap_index;
        w = 32'(word);
        if (i >= n) begin
            i = 0;
        end
        j = i + w / (32'h7FFF_FFFF / (n - i) + 1);
        if (j >= n) begin
            j = n - 1;
        end
        a = rank_node[i];
        b = rank_node[j];
        rank_node[i] = b;
        rank_node[j] = a;
        node_rank[b] = 7'(i);
        node_rank[a] = 7'(j);
        i++;
        if (i >= n) begin
            i = 0;
        end
        swap_index = i;
    endfunction

    function automatic void predict_emit();
        int          walk;
        int          hits;
        int          seen;
        t_arc_result r;
        walk = (edge_cnt_reg > EDGE_SLOTS) ? EDGE_SLOTS : int'(edge_cnt_reg);
        hits = 0;
        for (int k = 0; k < walk; k++) begin
            if (node_rank[arc_src[k]] > node_rank[arc_tgt[k]]) begin
                hits++;
            end
        end
        if (hits == 0) begin
            r.src     = '0;
            r.tgt     = '0;
            r.present = 1'b0;
            r.last    = 1'b1;
            expected_arcs.push_back(r);
        end else begin
            seen = 0;
            for (int k = 0; k < walk; k++) begin
                if (node_rank[arc_src[k]] > node_rank[arc_tgt[k]]) begin
                    seen++;
                    r.src     = arc_src[k];
                    r.tgt     = arc_tgt[k];
                    r.present = 1'b1;
                    r.last    = (seen == hits);
                    expected_arcs.push_back(r);
                end
            end
        end
    endfunction

    function automatic logic [30:0] draw_word();
        case ($urandom_range(7))
            0: begin
                return '0;
            end
            1: begin
                return WORD_MAX;
            end
            default: begin
                return 31'($urandom());
            end
        endcase
    endfunction

    function automatic void flag_arc(input t_arc_result got, input t_arc_result want,
                                     input bit orphan);
        if (mismatches < 10) begin
            if (orphan) begin
                $display("Unexpected result: src %0d tgt %0d present %0b last %0b",
                         got.src, got.tgt, got.present, got.last);
            end else begin
                $display("Mismatch: expected src %0d tgt %0d present %0b last %0b,",
                         want.src, want.tgt, want.present, want.last,
                         " got src %0d tgt %0d present %0b last %0b",
                         got.src, got.tgt, got.present, got.last);
            end
        end
        mismatches++;
    endfunction

    // The result channel is checked and its stall driven in the same process.
    always @(posedge i_clk) begin : arc_monitor
        t_arc_result got;
        t_arc_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.src     = o_out_source;
            got.tgt     = o_out_target;
            got.present = o_edge_present;
            got.last    = o_last;
            if (expected_arcs.size() == 0) begin
                flag_arc(got, got, 1'b1);
            end else begin
                want = expected_arcs.pop_front();
                if (got.src !== want.src || got.tgt !== want.tgt ||
                    got.present !== want.present || got.last !== want.last) begin
                    flag_arc(got, want, 1'b0);
                end
            end
        end
        i_out_stall <= (hold_left > 0) || (rx_idle_on && $urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holdoff_req) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(input logic [1:0] cmd, input logic [5:0] slot,
                                input logic [6:0] src, input logic [6:0] tgt,
                                input logic [30:0] word);
        while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_edge_slot   <= slot;
        i_source_node <= src;
        i_target_node <= tgt;
        i_random_word <= word;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        case (cmd)
            rofaf_pkg::CMD_LOAD: begin
                arc_src[slot] = src;
                arc_tgt[slot] = tgt;
            end
            rofaf_pkg::CMD_SHUFFLE: begin
                predict_shuffle(word);
            end
            rofaf_pkg::CMD_EMIT: begin
                predict_emit();
            end
            default: begin
            end
        endcase
    endtask

    task automatic load_arc(input logic [5:0] slot, input logic [6:0] src, input logic [6:0] tgt);
        send_request(rofaf_pkg::CMD_LOAD, slot, src, tgt, draw_word());
    endtask

    task automatic shuffle_once(input logic [30:0] word);
        send_request(rofaf_pkg::CMD_SHUFFLE, 6'($urandom()), 7'($urandom()), 7'($urandom()),
                     word);
    endtask

    task automatic emit_arcs();
        send_request(rofaf_pkg::CMD_EMIT, 6'($urandom()), 7'($urandom()), 7'($urandom()),
                     draw_word());
    endtask

    // A shuffle produces no result, so the block may still be busy after the last
    // expected result has arrived.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_arcs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == rofaf_pkg::CFG_NODE_COUNT) begin
            node_cnt_reg = value;
        end else begin
            edge_cnt_reg = value[6:0];
        end
    endtask

    task automatic configure(input logic [7:0] nodes, input logic [7:0] edges);
        settle();
        write_reg(rofaf_pkg::CFG_NODE_COUNT, nodes);
        write_reg(rofaf_pkg::CFG_EDGE_COUNT, edges);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_fill_edges();
        configure(8'd128, 8'd64);
        load_arc(6'd0, 7'd127, 7'd0);
        load_arc(6'd1, 7'd3, 7'd3);
        for (int s = 2; s < EDGE_SLOTS - 1; s++) begin
            load_arc(6'(s), 7'($urandom()), 7'($urandom()));
        end
        load_arc(6'd63, 7'd0, 7'd127);
    endtask

    task automatic test_emit_walks();
        emit_arcs();
        configure(8'd128, 8'd127);
        emit_arcs();
        configure(8'd128, 8'd0);
        emit_arcs();
        configure(8'd128, 8'd1);
        emit_arcs();
        load_arc(6'd0, 7'd0, 7'd127);
        emit_arcs();
        load_arc(6'd0, 7'd127, 7'd0);
    endtask

    task automatic test_unknown_command();
        send_request(CMD_NONE, 6'd0, 7'd5, 7'd0, WORD_MAX);
        send_request(CMD_NONE, 6'd63, 7'd127, 7'd127, '0);
        emit_arcs();
    endtask

    task automatic test_shuffle_corners();
        configure(8'd1, 8'd64);
        shuffle_once(WORD_MAX);
        shuffle_once('0);
        configure(8'd0, 8'd64);
        shuffle_once(WORD_MAX);
        configure(8'd255, 8'd64);
        shuffle_once('0);
        shuffle_once(WORD_MAX);
        shuffle_once(31'h4000_0000);
        emit_arcs();
        configure(8'd2, 8'd64);
        shuffle_once(WORD_MAX);
        emit_arcs();
    endtask

    task automatic test_output_holdoff();
        configure(8'd128, 8'd64);
        tx_idle_on  = 1'b0;
        holdoff_req <= 1'b1;
        while (hold_left == 0) begin
            @(posedge i_clk);
        end
        holdoff_req <= 1'b0;
        repeat (12) emit_arcs();
        tx_idle_on = 1'b1;
    endtask

    task automatic run_random_mix(input logic [7:0] nodes, input logic [7:0] edges,
                                  input int count, input bit steady);
        int          done;
        int          burst;
        int          pick;
        int unsigned n;
        logic [6:0]  src;
        logic [6:0]  tgt;
        configure(nodes, edges);
        tx_idle_on = !steady;
        rx_idle_on <= !steady;
        n = active_nodes();
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(1) == 0) begin
                    src = 7'($urandom_range(n - 1, 0));
                    tgt = 7'($urandom_range(n - 1, 0));
                end else begin
                    src = 7'($urandom());
                    tgt = 7'($urandom());
                end
                load_arc(6'($urandom()), src, tgt);
                done++;
            end else if (pick < 70) begin
                burst = $urandom_range(8, 1);
                repeat (burst) shuffle_once(draw_word());
                done += burst;
            end else if (pick < 95) begin
                emit_arcs();
                done++;
            end else begin
                send_request(CMD_NONE, 6'($urandom()), 7'($urandom()), 7'($urandom()),
                             draw_word());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_mix(8'd128, 8'd64, 35, 1'b0);
        run_random_mix(8'd255, 8'd127, 25, 1'b1);
        run_random_mix(8'd5, 8'd24, 25, 1'b0);
        run_random_mix(8'd0, 8'd64, 10, 1'b0);
        run_random_mix(8'($urandom_range(127, 2)), 8'($urandom_range(63, 1)), 25, 1'b0);
        run_random_mix(8'd128, 8'hC0, 20, 1'b0);
    endtask

    initial begin
        for (int k = 0; k < EDGE_SLOTS; k++) begin
            arc_src[k] = '0;
            arc_tgt[k] = '0;
        end
        for (int k = 0; k < NODE_SLOTS; k++) begin
            rank_node[k] = 7'(k);
            node_rank[k] = 7'(k);
        end
        swap_index   = 0;
        node_cnt_reg = 8'd1;
        edge_cnt_reg = 7'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_edges();
        test_emit_walks();
        test_unknown_command();
        test_shuffle_corners();
        test_output_holdoff();
        test_random_traffic();
        settle();
        if (mismatches == 0 && expected_arcs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### random_order_feedback_arc_filter_core.f
rtl/rofaf_pkg.sv
rtl/rofaf_div.sv
rtl/rofaf_perm.sv
rtl/random_order_feedback_arc_filter_core.sv
tb/tb_top.sv
